// ===== sv/rbd_pkg.sv =====
// Shared constants and types for the RGBA5551 2x2 box downscaler.
// No dependencies; imported by the interfaces, the top level and the checker.
`default_nettype none

package rbd_pkg;

  localparam int MAX_OUT_WIDTH = 512;
  localparam int COL_W         = $clog2(MAX_OUT_WIDTH);
  localparam int WIDTH_W       = 10;   // out_width register and source column
  localparam int CH_W          = 5;
  localparam int SUM_W         = CH_W + 1;
  localparam int ENTRY_W       = 3 * SUM_W;
  localparam int PIX_W         = 16;
  localparam int RGB_W         = 3 * CH_W;

  localparam int APB_ADDR_W    = 3;
  localparam int APB_DATA_W    = 32;

  // register indexes (paddr / 4)
  localparam logic REG_OUT_WIDTH = 1'b0;

  localparam logic [WIDTH_W-1:0] OUT_WIDTH_RST = WIDTH_W'(MAX_OUT_WIDTH);

  typedef logic [CH_W-1:0]    chan_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [ENTRY_W-1:0] entry_t;
  typedef logic [PIX_W-1:0]   pixel_t;

endpackage

`default_nettype wire

// ===== sv/rbd_if.sv =====
// Valid/ready channel interfaces for the downscaler: source pixels in,
// averaged pixels out. Depends on rbd_pkg.
`default_nettype none

interface rbd_in_if import rbd_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t pixel_in;
  logic   frame_start;

  modport source (output valid, output pixel_in, output frame_start, input ready);
  modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

interface rbd_out_if import rbd_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t pixel_out;
  logic   row_end;

  modport source (output valid, output pixel_out, output row_end, input ready);
  modport sink   (input valid, input pixel_out, input row_end, output ready);
endinterface

`default_nettype wire

// ===== sv/rbd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module rbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/rgba5551_box_downscale_2x2.sv =====
// 2x2 box-filter downscaler for RGBA5551 pixels, top level.
// Depends on rbd_pkg, rbd_in_if / rbd_out_if and rbd_ram.
//
// Usage:
//   up   : source pixels in raster order, 2*out_width per row. frame_start
//          on the first pixel of a frame clears the row and column counters.
//   down : one averaged pixel per 2x2 block, emitted while the second row of
//          each row pair streams in; row_end flags the last one of a row.
//   APB  : register 0 (byte address 0) is out_width, 10 bits, reset 512.
//          0 acts as 1, values above 512 act as 512. Write only when idle.
// Timing: one source pixel per clock while not stalled. An output pixel appears in
//   the cycle after the second pixel of its pair on the odd row is accepted. The pair
//   sums of the even row live in a 512 x 18 line RAM; its read is issued on
//   the first pixel of a pair, so the data is ready when the second arrives.
// Stall: up.ready drops only while an output pixel waits and down.ready is
//   low; the single output register is the only buffering.
// Reset: synchronous, clears counters, phase and output valid; the line RAM
//   is not cleared (every entry is written on an even row before its value is used).
`default_nettype none

module rgba5551_box_downscale_2x2 import rbd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  rbd_in_if.sink                     up,
  rbd_out_if.source                  down,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam logic [WIDTH_W:0] MAX_W = (WIDTH_W+1)'(MAX_OUT_WIDTH);

  logic [WIDTH_W-1:0] out_width;
  logic [RGB_W-1:0]   held_pixel;
  logic [WIDTH_W-1:0] source_column;
  logic               odd_row;
  logic               phase;

  logic               out_valid;
  pixel_t             out_pixel;
  logic               out_row_end;

  logic               accept;
  logic               phase_cur;
  logic [WIDTH_W-1:0] col_cur;
  logic               odd_cur;
  logic [RGB_W-1:0]   rgb;
  logic [WIDTH_W:0]   eff_w;
  logic [WIDTH_W:0]   col_inc;
  logic               last;
  sum_t               sum_r, sum_g, sum_b;
  entry_t             stored;
  logic [SUM_W:0]     tot_r, tot_g, tot_b;
  logic               ram_we, ram_re, emit;
  logic               reg_sel;

  // ---------------- configuration ----------------
  assign pready  = 1'b1;
  assign reg_sel = paddr[APB_ADDR_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_width <= OUT_WIDTH_RST;
    end else if (psel && penable && pwrite && reg_sel == REG_OUT_WIDTH) begin
      out_width <= pwdata[WIDTH_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == REG_OUT_WIDTH) begin
      prdata = APB_DATA_W'(out_width);
    end
  end

  always_comb begin
    if (out_width == '0) begin
      eff_w = (WIDTH_W+1)'(1);
    end else if ({1'b0, out_width} > MAX_W) begin
      eff_w = MAX_W;
    end else begin
      eff_w = {1'b0, out_width};
    end
  end

  // ---------------- datapath ----------------
  assign accept    = up.valid && up.ready;
  assign up.ready  = !out_valid || down.ready;

  // frame start clears the counters before the pixel is taken
  assign phase_cur = up.frame_start ? 1'b0 : phase;
  assign col_cur   = up.frame_start ? '0 : source_column;
  assign odd_cur   = up.frame_start ? 1'b0 : odd_row;
  assign rgb       = up.pixel_in[PIX_W-1:1];

  assign col_inc = {1'b0, col_cur} + (WIDTH_W+1)'(1);
  assign last    = col_inc >= eff_w;

  assign sum_r = SUM_W'(held_pixel[3*CH_W-1:2*CH_W]) + SUM_W'(rgb[3*CH_W-1:2*CH_W]);
  assign sum_g = SUM_W'(held_pixel[2*CH_W-1:CH_W])   + SUM_W'(rgb[2*CH_W-1:CH_W]);
  assign sum_b = SUM_W'(held_pixel[CH_W-1:0])        + SUM_W'(rgb[CH_W-1:0]);

  // even row writes pair sums; read is launched on the first pixel of a pair
  assign ram_we = accept && phase_cur && !odd_cur;
  assign ram_re = accept && !phase_cur;
  assign emit   = accept && phase_cur && odd_cur;

  rbd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_OUT_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (col_cur[COL_W-1:0]),
    .wdata ({sum_r, sum_g, sum_b}),
    .re    (ram_re),
    .raddr (col_cur[COL_W-1:0]),
    .rdata (stored)
  );

  assign tot_r = (SUM_W+1)'(sum_r) + (SUM_W+1)'(stored[3*SUM_W-1:2*SUM_W]);
  assign tot_g = (SUM_W+1)'(sum_g) + (SUM_W+1)'(stored[2*SUM_W-1:SUM_W]);
  assign tot_b = (SUM_W+1)'(sum_b) + (SUM_W+1)'(stored[SUM_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= 1'b0;
      source_column <= '0;
      odd_row       <= 1'b0;
      held_pixel    <= '0;
    end else if (accept) begin
      if (!phase_cur) begin
        held_pixel    <= rgb;
        phase         <= 1'b1;
        source_column <= col_cur;
        odd_row       <= odd_cur;
      end else begin
        phase         <= 1'b0;
        source_column <= last ? '0 : col_inc[WIDTH_W-1:0];
        odd_row       <= last ? !odd_cur : odd_cur;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (down.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pixel   <= {tot_r[SUM_W:2], tot_g[SUM_W:2], tot_b[SUM_W:2], 1'b1};
      out_row_end <= last;
    end
  end

  assign down.valid     = out_valid;
  assign down.pixel_out = out_pixel;
  assign down.row_end   = out_row_end;

endmodule

`default_nettype wire

// ===== sv/rbd_check.sv =====
// Port-level checker for the downscaler, bound to the top level.
// Depends on rbd_pkg and rgba5551_box_downscale_2x2.
`default_nettype none

module rbd_check import rbd_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  input wire logic   in_valid,
  input wire logic   in_ready,
  input wire logic   out_valid,
  input wire logic   out_ready,
  input wire pixel_t out_pixel,
  input wire logic   pready
);

  // alpha of every averaged pixel is forced on
  a_alpha_set: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_pixel[0])
    else $error("output alpha bit clear");

  // a new output item only follows an accepted input item
  a_out_after_in: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid && !out_ready)) |-> $past(in_valid && in_ready))
    else $error("output item without preceding input item");

  // input side stalls only behind a waiting output item
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with free output register");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output item dropped while stalled");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind rgba5551_box_downscale_2x2 rbd_check u_rbd_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (up.valid),
  .in_ready  (up.ready),
  .out_valid (down.valid),
  .out_ready (down.ready),
  .out_pixel (down.pixel_out),
  .pready    (pready)
);

`default_nettype wire
